// ===== rtl/core/esdf_bilinear_query_core_macros.svh =====
// assertion macros for the esdf bilinear query core
`ifndef ESDF_BILINEAR_QUERY_CORE_MACROS_SVH
`define ESDF_BILINEAR_QUERY_CORE_MACROS_SVH

// implication checked at every clock edge outside reset
`define EBQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ebq assertion failed");

// condition that must never hold outside reset
`define EBQ_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("ebq assertion failed");

`endif

// ===== rtl/core/ebq_pkg.sv =====
// shared types, codes and rounding helper of the esdf bilinear query core
`default_nettype none

package ebq_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNAVAIL = 2'd1,
        ST_OUT     = 2'd2
    } t_status;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPM        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANALYTIC   = 3'd5;

    // round a magnitude by 24 or 25 bits, apply sign, saturate to 32 bits
    function automatic logic [31:0] rnd_sat(input logic [63:0] p, input logic neg,
                                            input logic s25);
        logic [40:0] r;
        logic [40:0] nr;
        if (s25) begin
            r = 41'(p >> 25) + 41'(p[24]);
        end else begin
            r = 41'(p >> 24) + 41'(p[23]);
        end
        nr = -r;
        if (!neg) begin
            return (r > 41'h07fffffff) ? 32'h7fffffff : r[31:0];
        end
        return (r > 41'h080000000) ? 32'h80000000 : nr[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esdf_bilinear_query_core.sv =====
// top level of the esdf bilinear query core: banked cell grid and query pipeline
`default_nettype none

// Takes one request per clock cycle, loads and queries mixed freely; busy stays low
// because the pipeline never stalls. A query's result runs through the pipeline to
// the result register and is held on the result ports for one cycle with o_strobe
// high; the receiver cannot hold results off, so it must take every strobe. Loads
// give no result. The grid is kept in 16 banks interleaved by column mod 4 and row
// mod 4, each with one read port, so any 4x4 cell window (all that the center sample
// and the four finite-difference samples touch) is read in parallel; that window
// read sets the rate of one query per cycle. A load writes its cell in the window
// read stage, at the same pipeline position where queries read, so a query sees
// exactly the loads accepted before it. Cells that were never loaded read as unknown
// values. Configuration must be written only while no request is in flight; the
// block itself does not enforce this.
module esdf_bilinear_query_core #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic signed [31:0]              i_pos_x,
    input  logic signed [31:0]              i_pos_y,
    input  logic [7:0]                      i_cell_col,
    input  logic [7:0]                      i_cell_row,
    input  logic signed [15:0]              i_cell_value,
    input  logic                            i_cfg_we,
    input  logic [ebq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_strobe,
    output ebq_pkg::t_status                o_status,
    output logic signed [31:0]              o_dist_out,
    output logic signed [31:0]              o_grad_x,
    output logic signed [31:0]              o_grad_y
);
    import ebq_pkg::*;

`include "esdf_bilinear_query_core_macros.svh"

    // count widths (hold the size itself) and index widths
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CB  = $clog2(MAX_COLS);
    localparam int RB  = $clog2(MAX_ROWS);
    localparam int CIW = (CB < 3) ? 3 : CB;
    localparam int RIW = (RB < 3) ? 3 : RB;
    // bank address: row/4 and column/4
    localparam int BAW    = (CIW - 2) + (RIW - 2);
    localparam int BDEPTH = 1 << BAW;
    // sample coordinate widths, Q.16 signed with headroom for the one-cell offsets
    localparam int QXW = CNW + 18;
    localparam int QYW = RNW + 18;
    localparam int AXW = CNW + 3;
    localparam int AYW = RNW + 3;
    localparam int HALF = 32768;
    localparam int ONE  = 65536;
    localparam int NS   = 5;    // center, left, right, down, up

    typedef struct packed {
        logic           inb;
        logic [CNW-1:0] i0;
        logic [CNW-1:0] i1;
        logic [15:0]    t;
    } t_ax_x;

    typedef struct packed {
        logic           inb;
        logic [RNW-1:0] i0;
        logic [RNW-1:0] i1;
        logic [15:0]    t;
    } t_ax_y;

    // bounds check, clamp, floor and fraction along one axis
    function automatic t_ax_x axis_x(input logic signed [QXW-1:0] q, input logic [CNW-1:0] n);
        logic signed [QXW-1:0] hi;
        logic signed [QXW-1:0] lim;
        logic signed [QXW-1:0] x;
        logic [CNW:0]          nxt;
        t_ax_x                 a;
        hi    = $signed({2'b00, n, 16'h0000}) - QXW'(HALF);
        lim   = $signed({2'b00, n - CNW'(1), 16'h0000});
        a.inb = (q >= -QXW'(HALF)) && (q < hi);
        x     = (q < 0) ? '0 : q;
        if (x > lim) begin
            x = lim;
        end
        a.i0 = x[CNW+15:16];
        a.t  = x[15:0];
        nxt  = {1'b0, a.i0} + (CNW+1)'(1);
        a.i1 = (nxt < {1'b0, n}) ? nxt[CNW-1:0] : n - CNW'(1);
        return a;
    endfunction

    function automatic t_ax_y axis_y(input logic signed [QYW-1:0] q, input logic [RNW-1:0] n);
        logic signed [QYW-1:0] hi;
        logic signed [QYW-1:0] lim;
        logic signed [QYW-1:0] y;
        logic [RNW:0]          nxt;
        t_ax_y                 a;
        hi    = $signed({2'b00, n, 16'h0000}) - QYW'(HALF);
        lim   = $signed({2'b00, n - RNW'(1), 16'h0000});
        a.inb = (q >= -QYW'(HALF)) && (q < hi);
        y     = (q < 0) ? '0 : q;
        if (y > lim) begin
            y = lim;
        end
        a.i0 = y[RNW+15:16];
        a.t  = y[15:0];
        nxt  = {1'b0, a.i0} + (RNW+1)'(1);
        a.i1 = (nxt < {1'b0, n}) ? nxt[RNW-1:0] : n - RNW'(1);
        return a;
    endfunction

    // ---------------------------------------------------------------- config
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_cpm;
    logic [8:0]         r_map_width;
    logic [8:0]         r_map_height;
    logic               r_analytic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cpm        <= 32'h0001_0000;
            r_map_width  <= '0;
            r_map_height <= '0;
            r_analytic   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data;
                CFG_CPM:        r_cpm        <= i_cfg_data;
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[8:0];
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[8:0];
                CFG_ANALYTIC:   r_analytic   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // map sizes clamped to the grid capacity
    logic [12:0]    cols_w;
    logic [12:0]    rows_w;
    logic [CNW-1:0] cols;
    logic [RNW-1:0] rows;

    assign cols_w = (13'(r_map_width) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(r_map_width);
    assign rows_w = (13'(r_map_height) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(r_map_height);
    assign cols   = cols_w[CNW-1:0];
    assign rows   = rows_w[RNW-1:0];

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------- stage 1: capture
    logic               r1_v;
    logic               r1_func;
    logic signed [31:0] r1_px;
    logic signed [31:0] r1_py;
    logic [7:0]         r1_col;
    logic [7:0]         r1_row;
    logic signed [15:0] r1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        r1_func <= i_func;
        r1_px   <= i_pos_x;
        r1_py   <= i_pos_y;
        r1_col  <= i_cell_col;
        r1_row  <= i_cell_row;
        r1_val  <= i_cell_value;
    end

    // ---------------------------------------------------------------- stage 2: offset from origin
    logic signed [32:0] n_dx;
    logic signed [32:0] n_dy;
    logic signed [32:0] n_ndx;
    logic signed [32:0] n_ndy;

    assign n_dx  = $signed({r1_px[31], r1_px}) - $signed({r_origin_x[31], r_origin_x});
    assign n_dy  = $signed({r1_py[31], r1_py}) - $signed({r_origin_y[31], r_origin_y});
    assign n_ndx = -n_dx;
    assign n_ndy = -n_dy;

    logic               r2_v;
    logic               r2_func;
    logic               r2_negx;
    logic               r2_negy;
    logic [31:0]        r2_mx;
    logic [31:0]        r2_my;
    logic [7:0]         r2_col;
    logic [7:0]         r2_row;
    logic signed [15:0] r2_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_func <= r1_func;
        r2_negx <= n_dx[32];
        r2_negy <= n_dy[32];
        r2_mx   <= n_dx[32] ? n_ndx[31:0] : n_dx[31:0];
        r2_my   <= n_dy[32] ? n_ndy[31:0] : n_dy[31:0];
        r2_col  <= r1_col;
        r2_row  <= r1_row;
        r2_val  <= r1_val;
    end

    // ---------------------------------------------------------------- stage 3: scale to grid units
    logic               r3_v;
    logic               r3_func;
    logic               r3_negx;
    logic               r3_negy;
    logic [63:0]        r3_px;
    logic [63:0]        r3_py;
    logic [7:0]         r3_col;
    logic [7:0]         r3_row;
    logic signed [15:0] r3_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_func <= r2_func;
        r3_negx <= r2_negx;
        r3_negy <= r2_negy;
        r3_px   <= 64'(r2_mx) * 64'(r_cpm);
        r3_py   <= 64'(r2_my) * 64'(r_cpm);
        r3_col  <= r2_col;
        r3_row  <= r2_row;
        r3_val  <= r2_val;
    end

    // ---------------------------------------------------------------- stage 4: bounds and status
    logic     n_outx;
    logic     n_outy;
    t_status  n_status4;

    assign n_outx = r3_negx ? (r3_px != 64'd0) : (r3_px[63:16] >= 48'({cols, 16'h0000}));
    assign n_outy = r3_negy ? (r3_py != 64'd0) : (r3_py[63:16] >= 48'({rows, 16'h0000}));

    always_comb begin
        priority if ((r_cpm == 32'd0) || (cols == '0) || (rows == '0)) begin
            n_status4 = ST_UNAVAIL;
        end else if (n_outx || n_outy) begin
            n_status4 = ST_OUT;
        end else begin
            n_status4 = ST_OK;
        end
    end

    logic                  r4_v;
    logic                  r4_func;
    t_status               r4_status;
    logic signed [QXW-1:0] r4_qx;
    logic signed [QYW-1:0] r4_qy;
    logic [7:0]            r4_col;
    logic [7:0]            r4_row;
    logic signed [15:0]    r4_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_func   <= r3_func;
        r4_status <= n_status4;
        // sample point sits half a cell below the grid coordinate
        r4_qx     <= $signed({2'b00, r3_px[CNW+31:16]}) - QXW'(HALF);
        r4_qy     <= $signed({2'b00, r3_py[RNW+31:16]}) - QYW'(HALF);
        r4_col    <= r3_col;
        r4_row    <= r3_row;
        r4_val    <= r3_val;
    end

    // ---------------------------------------------------------------- stage 5: window read
    // axes: center, minus one cell, plus one cell
    t_ax_x ax [3];
    t_ax_y ay [3];

    always_comb begin
        ax[0] = axis_x(r4_qx, cols);
        ax[1] = axis_x(r4_qx - QXW'(ONE), cols);
        ax[2] = axis_x(r4_qx + QXW'(ONE), cols);
        ay[0] = axis_y(r4_qy, rows);
        ay[1] = axis_y(r4_qy - QYW'(ONE), rows);
        ay[2] = axis_y(r4_qy + QYW'(ONE), rows);
    end

    // window spans center floor - 1 .. + 2; each bank column holds one of them
    logic [CIW-3:0] col_part [4];
    logic [RIW-3:0] row_part [4];
    logic [BAW-1:0] raddr    [16];

    always_comb begin
        logic [1:0]     offx;
        logic [1:0]     offy;
        logic [AXW-1:0] cw;
        logic [AYW-1:0] rw;
        for (int b = 0; b < 4; b++) begin
            offx        = 2'(b) - ax[0].i0[1:0] + 2'd1;
            offy        = 2'(b) - ay[0].i0[1:0] + 2'd1;
            cw          = AXW'(ax[0].i0) + AXW'(offx) - AXW'(1);
            rw          = AYW'(ay[0].i0) + AYW'(offy) - AYW'(1);
            col_part[b] = cw[CIW-1:2];
            row_part[b] = rw[RIW-1:2];
        end
        for (int b = 0; b < 16; b++) begin
            raddr[b] = {row_part[b / 4], col_part[b % 4]};
        end
    end

    // load write, from the same stage where queries read
    logic [12:0]    colx;
    logic [12:0]    rowx;
    logic           wen;
    logic [3:0]     wbank;
    logic [BAW-1:0] waddr;

    assign colx  = 13'(r4_col);
    assign rowx  = 13'(r4_row);
    assign wen   = r4_v && !r4_func && (colx < 13'(MAX_COLS)) && (rowx < 13'(MAX_ROWS));
    assign wbank = {r4_row[1:0], r4_col[1:0]};
    assign waddr = {rowx[RIW-1:2], colx[CIW-1:2]};

    logic signed [15:0] rd [16];

    for (genvar g = 0; g < 16; g++) begin : g_bank
        logic signed [15:0] mem [BDEPTH];
        logic signed [15:0] r_q;

        always_ff @(posedge i_clk) begin
            if (wen && (wbank == 4'(g))) begin
                mem[waddr] <= r4_val;
            end
            r_q <= mem[raddr[g]];
        end

        assign rd[g] = r_q;
    end

    // per-sample cell banks and weights
    logic       n_sv [NS];
    logic [3:0] n_b  [NS][4];
    logic [15:0] n_tx [NS];
    logic [15:0] n_ty [NS];

    always_comb begin
        int xi;
        int yi;
        for (int s = 0; s < NS; s++) begin
            xi = (s == 1) ? 1 : ((s == 2) ? 2 : 0);
            yi = (s == 3) ? 1 : ((s == 4) ? 2 : 0);
            n_sv[s]   = ax[xi].inb && ay[yi].inb;
            n_b[s][0] = {ay[yi].i0[1:0], ax[xi].i0[1:0]};
            n_b[s][1] = {ay[yi].i0[1:0], ax[xi].i1[1:0]};
            n_b[s][2] = {ay[yi].i1[1:0], ax[xi].i0[1:0]};
            n_b[s][3] = {ay[yi].i1[1:0], ax[xi].i1[1:0]};
            n_tx[s]   = ax[xi].t;
            n_ty[s]   = ay[yi].t;
        end
    end

    logic        r5_v;
    t_status     r5_status;
    logic        r5_sv [NS];
    logic [3:0]  r5_b  [NS][4];
    logic [15:0] r5_tx [NS];
    logic [15:0] r5_ty [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v && r4_func;
        end
        r5_status <= r4_status;
        r5_sv     <= n_sv;
        r5_b      <= n_b;
        r5_tx     <= n_tx;
        r5_ty     <= n_ty;
    end

    // ---------------------------------------------------------------- stage 6: cell select
    // cell order per sample: d00, d10, d01, d11
    logic               r6_v;
    t_status            r6_status;
    logic               r6_sv [NS];
    logic signed [15:0] r6_d  [NS][4];
    logic [15:0]        r6_tx [NS];
    logic [15:0]        r6_ty [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_status <= r5_status;
        r6_sv     <= r5_sv;
        r6_tx     <= r5_tx;
        r6_ty     <= r5_ty;
        for (int s = 0; s < NS; s++) begin
            for (int k = 0; k < 4; k++) begin
                r6_d[s][k] <= rd[r5_b[s][k]];
            end
        end
    end

    // ---------------------------------------------------------------- stage 7: row blends and slopes
    logic signed [33:0] n_top [NS];
    logic signed [33:0] n_bot [NS];
    logic signed [34:0] n_sx;
    logic signed [34:0] n_sy;

    always_comb begin
        logic [16:0]        w0x;
        logic [16:0]        w0y;
        logic signed [16:0] da;
        logic signed [16:0] db;
        logic signed [16:0] dc;
        logic signed [16:0] dd;
        for (int s = 0; s < NS; s++) begin
            w0x      = 17'(ONE) - {1'b0, r6_tx[s]};
            n_top[s] = r6_d[s][0] * $signed({1'b0, w0x}) + r6_d[s][1] * $signed({2'b00, r6_tx[s]});
            n_bot[s] = r6_d[s][2] * $signed({1'b0, w0x}) + r6_d[s][3] * $signed({2'b00, r6_tx[s]});
        end
        w0x  = 17'(ONE) - {1'b0, r6_tx[0]};
        w0y  = 17'(ONE) - {1'b0, r6_ty[0]};
        da   = $signed({r6_d[0][1][15], r6_d[0][1]}) - $signed({r6_d[0][0][15], r6_d[0][0]});
        db   = $signed({r6_d[0][3][15], r6_d[0][3]}) - $signed({r6_d[0][2][15], r6_d[0][2]});
        dc   = $signed({r6_d[0][2][15], r6_d[0][2]}) - $signed({r6_d[0][0][15], r6_d[0][0]});
        dd   = $signed({r6_d[0][3][15], r6_d[0][3]}) - $signed({r6_d[0][1][15], r6_d[0][1]});
        n_sx = da * $signed({1'b0, w0y}) + db * $signed({2'b00, r6_ty[0]});
        n_sy = dc * $signed({1'b0, w0x}) + dd * $signed({2'b00, r6_tx[0]});
    end

    logic               r7_v;
    t_status            r7_status;
    logic               r7_sv  [NS];
    logic signed [33:0] r7_top [NS];
    logic signed [33:0] r7_bot [NS];
    logic [15:0]        r7_ty  [NS];
    logic signed [34:0] r7_sx;
    logic signed [34:0] r7_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_status <= r6_status;
        r7_sv     <= r6_sv;
        r7_top    <= n_top;
        r7_bot    <= n_bot;
        r7_ty     <= r6_ty;
        r7_sx     <= n_sx;
        r7_sy     <= n_sy;
    end

    // ---------------------------------------------------------------- stage 8: column blend, Q8.40
    logic signed [51:0] n_v40 [NS];
    logic signed [34:0] n_nsx;
    logic signed [34:0] n_nsy;

    always_comb begin
        logic [16:0] w0y;
        for (int s = 0; s < NS; s++) begin
            w0y      = 17'(ONE) - {1'b0, r7_ty[s]};
            n_v40[s] = r7_top[s] * $signed({1'b0, w0y}) + r7_bot[s] * $signed({2'b00, r7_ty[s]});
        end
    end

    assign n_nsx = -r7_sx;
    assign n_nsy = -r7_sy;

    logic               r8_v;
    t_status            r8_status;
    logic               r8_sv  [NS];
    logic signed [51:0] r8_v40 [NS];
    logic               r8_sxn;
    logic               r8_syn;
    logic [31:0]        r8_sxm;
    logic [31:0]        r8_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_status <= r7_status;
        r8_sv     <= r7_sv;
        r8_v40    <= n_v40;
        r8_sxn    <= r7_sx[34];
        r8_syn    <= r7_sy[34];
        r8_sxm    <= r7_sx[34] ? n_nsx[31:0] : r7_sx[31:0];
        r8_sym    <= r7_sy[34] ? n_nsy[31:0] : r7_sy[31:0];
    end

    // ---------------------------------------------------------------- stage 9: rounding, analytic scale
    logic signed [33:0] n_v24 [NS];
    logic signed [31:0] n_dist;

    always_comb begin
        logic               neg;
        logic signed [51:0] nv;
        logic [51:0]        mag;
        logic [35:0]        r16;
        logic [35:0]        nr16;
        logic [31:0]        r24;
        n_dist = '0;
        for (int s = 0; s < NS; s++) begin
            neg      = r8_v40[s][51];
            nv       = -r8_v40[s];
            mag      = neg ? nv : r8_v40[s];
            r16      = 36'(mag >> 16) + 36'(mag[15]);
            nr16     = -r16;
            n_v24[s] = neg ? $signed(nr16[33:0]) : $signed(r16[33:0]);
            if (s == 0) begin
                r24    = 32'(mag >> 24) + 32'(mag[23]);
                n_dist = neg ? -$signed(r24) : $signed(r24);
            end
        end
    end

    logic               r9_v;
    t_status            r9_status;
    logic               r9_sv  [NS];
    logic signed [33:0] r9_v24 [NS];
    logic signed [31:0] r9_dist;
    logic               r9_sxn;
    logic               r9_syn;
    logic [63:0]        r9_apx;
    logic [63:0]        r9_apy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else begin
            r9_v <= r8_v;
        end
        r9_status <= r8_status;
        r9_sv     <= r8_sv;
        r9_v24    <= n_v24;
        r9_dist   <= n_dist;
        r9_sxn    <= r8_sxn;
        r9_syn    <= r8_syn;
        r9_apx    <= 64'(r8_sxm) * 64'(r_cpm);
        r9_apy    <= 64'(r8_sym) * 64'(r_cpm);
    end

    // ---------------------------------------------------------------- stage 10: difference select
    // central difference when both neighbors lie inside, else one-sided, else zero
    logic               n_fxz;
    logic               n_fyz;
    logic               n_fxh;
    logic               n_fyh;
    logic signed [34:0] n_fxd;
    logic signed [34:0] n_fyd;
    logic signed [34:0] n_nfxd;
    logic signed [34:0] n_nfyd;

    always_comb begin
        n_fxh = r9_sv[1] && r9_sv[2];
        n_fyh = r9_sv[3] && r9_sv[4];
        n_fxz = !r9_sv[1] && !r9_sv[2];
        n_fyz = !r9_sv[3] && !r9_sv[4];
        priority if (n_fxh) begin
            n_fxd = 35'(r9_v24[2]) - 35'(r9_v24[1]);
        end else if (r9_sv[2]) begin
            n_fxd = 35'(r9_v24[2]) - 35'(r9_v24[0]);
        end else begin
            n_fxd = 35'(r9_v24[0]) - 35'(r9_v24[1]);
        end
        priority if (n_fyh) begin
            n_fyd = 35'(r9_v24[4]) - 35'(r9_v24[3]);
        end else if (r9_sv[4]) begin
            n_fyd = 35'(r9_v24[4]) - 35'(r9_v24[0]);
        end else begin
            n_fyd = 35'(r9_v24[0]) - 35'(r9_v24[3]);
        end
        n_nfxd = -n_fxd;
        n_nfyd = -n_fyd;
    end

    logic               r10_v;
    t_status            r10_status;
    logic signed [31:0] r10_dist;
    logic [31:0]        r10_agx;
    logic [31:0]        r10_agy;
    logic               r10_fxz;
    logic               r10_fyz;
    logic               r10_fxh;
    logic               r10_fyh;
    logic               r10_fxn;
    logic               r10_fyn;
    logic [31:0]        r10_fxm;
    logic [31:0]        r10_fym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else begin
            r10_v <= r9_v;
        end
        r10_status <= r9_status;
        r10_dist   <= r9_dist;
        r10_agx    <= rnd_sat(r9_apx, r9_sxn, 1'b0);
        r10_agy    <= rnd_sat(r9_apy, r9_syn, 1'b0);
        r10_fxz    <= n_fxz;
        r10_fyz    <= n_fyz;
        r10_fxh    <= n_fxh;
        r10_fyh    <= n_fyh;
        r10_fxn    <= n_fxd[34];
        r10_fyn    <= n_fyd[34];
        r10_fxm    <= n_fxd[34] ? n_nfxd[31:0] : n_fxd[31:0];
        r10_fym    <= n_fyd[34] ? n_nfyd[31:0] : n_fyd[31:0];
    end

    // ---------------------------------------------------------------- stage 11: difference scale
    logic               r11_v;
    t_status            r11_status;
    logic signed [31:0] r11_dist;
    logic [31:0]        r11_agx;
    logic [31:0]        r11_agy;
    logic               r11_fxz;
    logic               r11_fyz;
    logic               r11_fxh;
    logic               r11_fyh;
    logic               r11_fxn;
    logic               r11_fyn;
    logic [63:0]        r11_fpx;
    logic [63:0]        r11_fpy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= r10_v;
        end
        r11_status <= r10_status;
        r11_dist   <= r10_dist;
        r11_agx    <= r10_agx;
        r11_agy    <= r10_agy;
        r11_fxz    <= r10_fxz;
        r11_fyz    <= r10_fyz;
        r11_fxh    <= r10_fxh;
        r11_fyh    <= r10_fyh;
        r11_fxn    <= r10_fxn;
        r11_fyn    <= r10_fyn;
        r11_fpx    <= 64'(r10_fxm) * 64'(r_cpm);
        r11_fpy    <= 64'(r10_fym) * 64'(r_cpm);
    end

    // ---------------------------------------------------------------- stage 12: result register
    logic [31:0] n_gx;
    logic [31:0] n_gy;

    always_comb begin
        if (r_analytic) begin
            n_gx = r11_agx;
            n_gy = r11_agy;
        end else begin
            // central difference is halved by the extra shift
            n_gx = r11_fxz ? 32'd0 : rnd_sat(r11_fpx, r11_fxn, r11_fxh);
            n_gy = r11_fyz ? 32'd0 : rnd_sat(r11_fpy, r11_fyn, r11_fyh);
        end
    end

    logic               r_strobe;
    t_status            r_status;
    logic signed [31:0] r_dist;
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r11_v;
        end
        r_status <= r11_status;
        // non-ok results carry zero payload
        r_dist   <= (r11_status == ST_OK) ? r11_dist : 32'sd0;
        r_gx     <= (r11_status == ST_OK) ? $signed(n_gx) : 32'sd0;
        r_gy     <= (r11_status == ST_OK) ? $signed(n_gy) : 32'sd0;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_dist_out = r_dist;
    assign o_grad_x   = r_gx;
    assign o_grad_y   = r_gy;

    // ---------------------------------------------------------------- assertions
    // every result traces back to an accepted query request
    `EBQ_ASSERT_IMP(a_strobe_from_query, o_strobe, $past(start && !busy && i_func, 12))
    // non-ok results carry zero payload
    `EBQ_ASSERT_IMP(a_fail_zero, o_strobe && (o_status != ST_OK),
                    (o_dist_out == 32'sd0) && (o_grad_x == 32'sd0) && (o_grad_y == 32'sd0))
    // an ok result needs a usable map
    `EBQ_ASSERT_NEVER(a_ok_needs_map, o_strobe && (o_status == ST_OK) &&
                      ((r_cpm == 32'd0) || (cols == '0) || (rows == '0)))

endmodule

`default_nettype wire

// ===== tb/esdf_bilinear_query_core_tb.sv =====
// testbench of the esdf bilinear query core: directed and random loads and queries
`timescale 1ns / 100ps

module esdf_bilinear_query_core_tb;
    import ebq_pkg::*;

    localparam int  GRID_DIM    = 256;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  ITEM_GOAL   = 900;
    localparam int  CALM_AFTER  = 760;  // no idling once this many requests went out
    localparam int  DRAIN_WAIT  = 20;   // result latency plus margin for pending loads

    typedef struct {
        t_status     status;
        logic [31:0] dist_val;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
    } t_query_result;

    // predictor of the query core plus the store of results still due
    class esdf_scoreboard;
        shortint       grid[GRID_DIM*GRID_DIM];
        bit            loaded[GRID_DIM*GRID_DIM];
        longint        org_x, org_y;
        bit [63:0]     cpm = 64'd65536;
        int            width_reg, height_reg;
        bit            analytic = 1'b1;
        t_query_result due[$];
        int            mismatches, strays, n_loads, n_ok, n_unavail, n_out;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ORIGIN_X:   org_x = longint'($signed(data));
                CFG_ORIGIN_Y:   org_y = longint'($signed(data));
                CFG_CPM:        cpm = 64'(data);
                CFG_MAP_WIDTH:  width_reg = int'(data[8:0]);
                CFG_MAP_HEIGHT: height_reg = int'(data[8:0]);
                CFG_ANALYTIC:   analytic = data[0];
                default: ;
            endcase
        endfunction

        function longint cols();
            return width_reg > GRID_DIM ? GRID_DIM : width_reg;
        endfunction

        function longint rows();
            return height_reg > GRID_DIM ? GRID_DIM : height_reg;
        endfunction

        // round(v * mul / 2^s), half away from zero
        function longint scale_round(longint v, bit [63:0] mul, int s);
            bit        neg;
            bit [63:0] m;
            bit [63:0] p;
            bit [63:0] r;
            neg = v < 0;
            m = neg ? 64'(-v) : 64'(v);
            p = m * mul;
            r = (p >> s) + ((p >> (s - 1)) & 64'd1);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint cell_at(longint c, longint r);
            return longint'(grid[r*GRID_DIM + c]);
        endfunction

        // bilinear value in Q8.40 and grid slopes in Q8.24 at sample point q
        function bit interp(longint qx, longint qy, longint nc, longint nr,
                            output longint v40, output longint sx, output longint sy);
            longint x, y, x0, y0, x1, y1, tx, ty;
            longint d00, d10, d01, d11, top, bot;
            v40 = 0; sx = 0; sy = 0;
            if (qx < -32768 || qy < -32768 ||
                qx >= nc*65536 - 32768 || qy >= nr*65536 - 32768)
                return 1'b0;
            x = qx < 0 ? 0 : qx;
            y = qy < 0 ? 0 : qy;
            if (x > (nc - 1)*65536) x = (nc - 1)*65536;
            if (y > (nr - 1)*65536) y = (nr - 1)*65536;
            x0 = x >>> 16;
            y0 = y >>> 16;
            tx = x & 65535;
            ty = y & 65535;
            x1 = x0 + 1 < nc ? x0 + 1 : nc - 1;
            y1 = y0 + 1 < nr ? y0 + 1 : nr - 1;
            d00 = cell_at(x0, y0);
            d10 = cell_at(x1, y0);
            d01 = cell_at(x0, y1);
            d11 = cell_at(x1, y1);
            top = d00*(65536 - tx) + d10*tx;
            bot = d01*(65536 - tx) + d11*tx;
            v40 = top*(65536 - ty) + bot*ty;
            sx = (d10 - d00)*(65536 - ty) + (d11 - d01)*ty;
            sy = (d01 - d00)*(65536 - tx) + (d11 - d10)*tx;
            return 1'b1;
        endfunction

        function bit sample_q24(longint qx, longint qy, longint nc, longint nr,
                                output longint v);
            longint v40, a, b;
            v = 0;
            if (!interp(qx, qy, nc, nr, v40, a, b)) return 1'b0;
            v = scale_round(v40, 64'd1, 16);
            return 1'b1;
        endfunction

        // central difference, one-sided near the edges, zero if no neighbor fits
        function longint diff_slope(longint qx, longint qy, longint ex, longint ey,
                                    longint nc, longint nr);
            longint c, l, r;
            bit     hl, hr;
            hl = sample_q24(qx - ex, qy - ey, nc, nr, l);
            hr = sample_q24(qx + ex, qy + ey, nc, nr, r);
            void'(sample_q24(qx, qy, nc, nr, c));
            if (hl && hr) return sat32(scale_round(r - l, cpm, 25));
            if (hr) return sat32(scale_round(r - c, cpm, 24));
            if (hl) return sat32(scale_round(c - l, cpm, 24));
            return 0;
        endfunction

        // world to grid in Q16.16, 0 when below zero or at/above the size
        function bit to_grid(logic [31:0] pos, longint org, longint size, output longint g);
            longint    d;
            bit [63:0] m, p;
            g = 0;
            d = longint'($signed(pos)) - org;
            m = d < 0 ? 64'(-d) : 64'(d);
            p = m * cpm;
            if (d < 0) return p == 64'd0;
            if ((p >> 16) >= 64'(size) << 16) return 1'b0;
            g = longint'(p >> 16);
            return 1'b1;
        endfunction

        function t_query_result predict_query(logic [31:0] px, logic [31:0] py);
            t_query_result res;
            longint        gx, gy, v40, sx, sy;
            res = '{ST_OK, 32'd0, 32'd0, 32'd0};
            if (cpm == 0 || cols() == 0 || rows() == 0) begin
                res.status = ST_UNAVAIL;
                return res;
            end
            if (!to_grid(px, org_x, cols(), gx) || !to_grid(py, org_y, rows(), gy)) begin
                res.status = ST_OUT;
                return res;
            end
            gx -= 32768;
            gy -= 32768;
            void'(interp(gx, gy, cols(), rows(), v40, sx, sy));
            res.dist_val = 32'(sat32(scale_round(v40, 64'd1, 24)));
            if (analytic) begin
                res.grad_x = 32'(sat32(scale_round(sx, cpm, 24)));
                res.grad_y = 32'(sat32(scale_round(sy, cpm, 24)));
            end else begin
                res.grad_x = 32'(diff_slope(gx, gy, 65536, 0, cols(), rows()));
                res.grad_y = 32'(diff_slope(gx, gy, 0, 65536, cols(), rows()));
            end
            return res;
        endfunction

        // true when an ok query here could read a cell never loaded
        function bit touches_unloaded(logic [31:0] px, logic [31:0] py);
            longint gx, gy, c, r;
            if (cpm == 0 || cols() == 0 || rows() == 0) return 1'b0;
            if (!to_grid(px, org_x, cols(), gx) || !to_grid(py, org_y, rows(), gy))
                return 1'b0;
            for (r = (gy >>> 16) - 2; r <= (gy >>> 16) + 2; r++)
                for (c = (gx >>> 16) - 2; c <= (gx >>> 16) + 2; c++)
                    if (c >= 0 && r >= 0 && c < cols() && r < rows() &&
                        !loaded[r*GRID_DIM + c])
                        return 1'b1;
            return 1'b0;
        endfunction

        function void note_request(logic func, logic [31:0] px, logic [31:0] py,
                                   logic [7:0] col, logic [7:0] row, logic [15:0] val);
            t_query_result res;
            if (!func) begin
                grid[row*GRID_DIM + col] = shortint'(val);
                loaded[row*GRID_DIM + col] = 1'b1;
                n_loads++;
                return;
            end
            res = predict_query(px, py);
            case (res.status)
                ST_OK:      n_ok++;
                ST_UNAVAIL: n_unavail++;
                default:    n_out++;
            endcase
            due.push_back(res);
        endfunction

        function void check_result(t_status st, logic [31:0] d, logic [31:0] gx,
                                   logic [31:0] gy);
            t_query_result want;
            if (due.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("unexpected result: status %0d dist %h", st, d);
                return;
            end
            want = due.pop_front();
            if (st !== want.status || d !== want.dist_val || gx !== want.grad_x ||
                gy !== want.grad_y) begin
                mismatches++;
                if (mismatches + strays <= 10)
                    $display("mismatch: exp st %0d d %h gx %h gy %h, got st %0d d %h gx %h gy %h",
                             want.status, want.dist_val, want.grad_x, want.grad_y,
                             st, d, gx, gy);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_func;
    logic signed [31:0]    i_pos_x;
    logic signed [31:0]    i_pos_y;
    logic [7:0]            i_cell_col;
    logic [7:0]            i_cell_row;
    logic signed [15:0]    i_cell_value;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [31:0]           i_cfg_data;
    logic                  o_strobe;
    t_status               o_status;
    logic signed [31:0]    o_dist_out;
    logic signed [31:0]    o_grad_x;
    logic signed [31:0]    o_grad_y;

    esdf_scoreboard sb = new();
    int             cycle_count;
    int             queries_sent;
    int             items_sent;
    int             phase_count;
    bit             idle_on;

    esdf_bilinear_query_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_cell_value (i_cell_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_dist_out   (o_dist_out),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("esdf_bilinear_query_core verification failed");
            $finish;
        end
    end

    // result monitor: every strobe must be taken, there is no back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_status, o_dist_out, o_grad_x, o_grad_y);
    end

    // one request, held until accepted, then an optional idle burst
    task automatic send_request(logic func, logic [31:0] px, logic [31:0] py,
                                logic [7:0] col, logic [7:0] row, logic [15:0] val);
        start        <= 1'b1;
        i_func       <= func;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_cell_col   <= col;
        i_cell_row   <= row;
        i_cell_value <= val;
        do @(posedge i_clk); while (busy);
        sb.note_request(func, px, py, col, row, val);
        items_sent++;
        if (func) queries_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // wait until every due result came, then let pending loads settle
    task automatic drain();
        start <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // drain, then write all six registers back to back
    task automatic config_map(logic [31:0] ox, logic [31:0] oy, logic [31:0] cpm,
                              logic [8:0] w, logic [8:0] h, logic an);
        logic [31:0] vals[6];
        int          k;
        drain();
        vals = '{ox, oy, cpm, 32'(w), 32'(h), 32'(an)};
        for (k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.write_reg(CFG_IDX_W'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // world position whose grid coordinate is about g (Q16.16 cells)
    function automatic logic [31:0] pos_from_grid(longint org, bit [63:0] cpm, longint g);
        longint d, p;
        if (cpm == 0) return $urandom;
        d = (g*65536 + longint'(cpm) - 1) / longint'(cpm);
        p = org + d;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        return p[31:0];
    endfunction

    function automatic logic [15:0] cell_value_pick();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one configuration: load a cell block, then queries aimed mostly at it
    task automatic run_phase(int n_items);
        logic [31:0] ox, oy, cpm, px, py;
        logic [8:0]  w, h;
        longint      nc, nr, bw, bh, bx, by, gx, gy;
        int          i, c, r, pick;
        ox = 32'($signed($urandom_range(0, 40*65536)) - 20*65536);
        oy = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 65536*8));
        case ($urandom_range(0, 9))
            0:       cpm = 32'd32768;
            1:       cpm = 32'd131072;
            2:       cpm = 32'd262144;
            3, 4:    cpm = $urandom_range(4096, 1 << 20);
            default: cpm = 32'd65536;
        endcase
        w = 9'($urandom_range(1, 8));
        h = 9'($urandom_range(1, 8));
        if ($urandom_range(0, 5) == 0) w = 9'($urandom_range(9, 255));
        if ($urandom_range(0, 5) == 0) h = 9'($urandom_range(9, 255));
        // extremes of the registers in the early phases
        case (phase_count)
            0: begin w = 9'd256; h = 9'd511; end
            1: cpm = 32'hffffffff;
            2: begin ox = 32'h80000000; cpm = 32'd1; end
            3: begin ox = 32'h7fff0000; oy = 32'h80000000; end
            4: w = 9'd0;
            5: cpm = 32'd0;
            6: begin w = 9'd511; h = 9'd256; cpm = 32'h00ffffff; end
            default: ;
        endcase
        phase_count++;
        config_map(ox, oy, cpm, w, h, 1'($urandom));
        nc = sb.cols() == 0 ? 8 : sb.cols();
        nr = sb.rows() == 0 ? 8 : sb.rows();
        bw = nc < 6 ? nc : longint'($urandom_range(5, 6));
        bh = nr < 6 ? nr : longint'($urandom_range(5, 6));
        bx = $urandom_range(0, 1) ? nc - bw : longint'($urandom_range(0, int'(nc - bw)));
        by = $urandom_range(0, 1) ? 0 : longint'($urandom_range(0, int'(nr - bh)));
        for (r = int'(by); r < by + bh; r++)
            for (c = int'(bx); c < bx + bw; c++)
                send_request(1'b0, $urandom, $urandom, 8'(c), 8'(r), cell_value_pick());
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            gx = bx*65536 + longint'($urandom_range(0, int'(bw*65536 - 1)));
            gy = by*65536 + longint'($urandom_range(0, int'(bh*65536 - 1)));
            px = pos_from_grid(sb.org_x, sb.cpm, gx);
            py = pos_from_grid(sb.org_y, sb.cpm, gy);
            if (pick >= 70 && pick < 80) begin
                // noise position anywhere
                px = $urandom;
                py = $urandom;
            end else if (pick >= 80 && pick < 88) begin
                // just past the far edge or just below the origin
                if ($urandom_range(0, 1))
                    px = pos_from_grid(sb.org_x, sb.cpm,
                                       nc*65536 + $urandom_range(0, 3*65536));
                else
                    py = 32'(sb.org_y - longint'($urandom_range(1, 65536)));
            end
            if (pick >= 88 || sb.touches_unloaded(px, py))
                send_request(1'b0, px, py, 8'(bx + $urandom_range(0, int'(bw - 1))),
                             8'(by + $urandom_range(0, int'(bh - 1))), cell_value_pick());
            else
                send_request(1'b1, px, py, 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= 1'b0;
        i_pos_x      <= '0;
        i_pos_y      <= '0;
        i_cell_col   <= '0;
        i_cell_row   <= '0;
        i_cell_value <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ORIGIN_X;
        i_cfg_data   <= '0;
        cycle_count  <= 0;
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty map after reset, then a 2x2 map with extreme cells
        send_request(1'b1, 32'h00010000, 32'h00010000, 8'd0, 8'd0, 16'd0);
        config_map(32'd0, 32'd0, 32'd65536, 9'd2, 9'd2, 1'b1);
        send_request(1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'h7fff);
        send_request(1'b0, 32'd0, 32'd0, 8'd1, 8'd0, 16'h8000);
        send_request(1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'h0000);
        send_request(1'b0, 32'd0, 32'd0, 8'd1, 8'd1, 16'h0001);
        send_request(1'b1, 32'h00000000, 32'h00000000, 8'd0, 8'd0, 16'd0);
        send_request(1'b1, 32'h00010000, 32'h00010000, 8'd0, 8'd0, 16'd0);
        send_request(1'b1, 32'h0001ffff, 32'h0001ffff, 8'd0, 8'd0, 16'd0);
        send_request(1'b1, 32'h00020000, 32'h00000000, 8'd0, 8'd0, 16'd0);  // right edge
        send_request(1'b1, 32'hffffffff, 32'h00008000, 8'd0, 8'd0, 16'd0);  // below origin
        send_request(1'b1, 32'h7fffffff, 32'h80000000, 8'd0, 8'd0, 16'd0);
        // finite differences on the same map
        config_map(32'd0, 32'd0, 32'd65536, 9'd2, 9'd2, 1'b0);
        send_request(1'b1, 32'h00008000, 32'h00008000, 8'd0, 8'd0, 16'd0);
        send_request(1'b1, 32'h00018000, 32'h00010000, 8'd0, 8'd0, 16'd0);
        // single cell map: no neighbor for a difference
        config_map(32'd0, 32'd0, 32'd65536, 9'd1, 9'd1, 1'b0);
        send_request(1'b1, 32'h00004000, 32'h00004000, 8'd0, 8'd0, 16'd0);
        // zero resolution means no map
        config_map(32'd0, 32'd0, 32'd0, 9'd2, 9'd2, 1'b1);
        send_request(1'b1, 32'h00004000, 32'h00004000, 8'd0, 8'd0, 16'd0);

        // random phases; the tail runs with no idling
        while (items_sent < ITEM_GOAL) begin
            idle_on = items_sent < CALM_AFTER;
            run_phase($urandom_range(40, 80));
        end
        drain();

        $display("covered %0d loads and %0d queries over %0d map settings",
                 sb.n_loads, queries_sent, phase_count + 4);
        $display("query outcomes: %0d ok, %0d no map, %0d outside; %0d bad, %0d stray, %0d left",
                 sb.n_ok, sb.n_unavail, sb.n_out, sb.mismatches, sb.strays, sb.due.size());
        if (sb.mismatches == 0 && sb.strays == 0 && sb.due.size() == 0) begin
            $display("esdf_bilinear_query_core verification clean");
        end else begin
            $display("esdf_bilinear_query_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ebq_pkg.sv
rtl/core/esdf_bilinear_query_core.sv
tb/esdf_bilinear_query_core_tb.sv
